FILE: src/nested_list_element_splitter_top_macros.svh
// Assertion helpers shared by the splitter RTL.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef NESTED_LIST_ELEMENT_SPLITTER_TOP_MACROS_SVH
`define NESTED_LIST_ELEMENT_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds in the same cycle as its trigger.
`define NLES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define NLES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NLES_ASSERT_SAME(lbl, ante, cons, msg)
`define NLES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/nles_pkg.sv
package nles_pkg;

	// Size limits of the text and of the bracket nesting
	localparam longint unsigned MAX_LEN   = 64'd65536;
	localparam longint unsigned MAX_DEPTH = 64'd255;

	// Saturation points of position and nesting level
	localparam logic [15:0] POS_CAP =
		((MAX_LEN - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(MAX_LEN - 64'd1);
	localparam logic [7:0] DEPTH_CAP =
		(MAX_DEPTH > 64'd255) ? 8'hFF : 8'(MAX_DEPTH);

	// Byte codes
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_OPEN_SQ  = 8'h5B;
	localparam logic [7:0] CH_OPEN_CU  = 8'h7B;
	localparam logic [7:0] CH_OPEN_PA  = 8'h28;
	localparam logic [7:0] CH_OPEN_AN  = 8'h3C;
	localparam logic [7:0] CH_CLOSE_SQ = 8'h5D;
	localparam logic [7:0] CH_CLOSE_CU = 8'h7D;
	localparam logic [7:0] CH_CLOSE_PA = 8'h29;
	localparam logic [7:0] CH_CLOSE_AN = 8'h3E;

	// One result item
	typedef struct packed {
		logic        elem_valid;
		logic [15:0] elem_start;
		logic [15:0] elem_end;
		logic        string_done;
		logic        overflow;
	} nles_result_t;

	function automatic logic is_opener(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_OPEN_SQ, CH_OPEN_CU, CH_OPEN_PA, CH_OPEN_AN: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_closer(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_CLOSE_SQ, CH_CLOSE_CU, CH_CLOSE_PA, CH_CLOSE_AN: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/nles_core.sv
`include "nested_list_element_splitter_top_macros.svh"

module nles_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            ch,
	input  logic                  last,
	output logic                  has_result,
	output nles_pkg::nles_result_t result
);
	import nles_pkg::*;

	logic [15:0] pos_q, pos_d;
	logic [7:0]  level_q, level_d;
	logic        quote_q, quote_d;
	logic        skip_q, skip_d;
	logic        have_q, have_d;
	logic [15:0] start_q, start_d;
	logic [15:0] end_q, end_d;
	logic        sat_q, sat_d;
	logic        ends;
	logic        take;
	logic        stop;
	logic [16:0] end_ext;

	// Per-byte update of nesting, quoting and the pending element
	always_comb begin
		pos_d   = pos_q;
		level_d = level_q;
		quote_d = quote_q;
		skip_d  = skip_q;
		have_d  = have_q;
		start_d = start_q;
		end_d   = end_q;
		sat_d   = sat_q;
		ends    = 1'b0;
		take    = 1'b1;
		stop    = 1'b0;
		end_ext = {1'b0, pos_q} + 17'd1;
		if (!last) begin
			// advance position, hold at the cap
			if (pos_q < POS_CAP) begin
				pos_d = pos_q + 16'd1;
			end else begin
				sat_d = 1'b1;
			end
			// drop the outer opener and a comma right after a closing element
			if (pos_q == 16'd0) begin
				stop = 1'b1;
			end else if (skip_q) begin
				skip_d = 1'b0;
				if (ch == CH_COMMA) begin
					stop = 1'b1;
				end
			end
			if (!stop) begin
				if (quote_q) begin
					if (ch == CH_QUOTE) begin
						quote_d = 1'b0;
					end
				end else if (level_q == 8'd1 && ch == CH_COMMA) begin
					ends = 1'b1;
					take = 1'b0;
				end else if (ch == CH_QUOTE) begin
					quote_d = 1'b1;
				end else if (is_opener(ch)) begin
					if (level_q < DEPTH_CAP) begin
						level_d = level_q + 8'd1;
					end else begin
						sat_d = 1'b1;
					end
				end else if (is_closer(ch)) begin
					if (level_q == 8'd1) begin
						ends   = 1'b1;
						skip_d = 1'b1;
					end else begin
						level_d = level_q - 8'd1;
					end
				end
				// extend the trimmed element over a text byte
				if (take && ch > CH_SPACE) begin
					if (!have_q) begin
						have_d  = 1'b1;
						start_d = pos_q;
					end
					if (end_ext > {1'b0, POS_CAP}) begin
						end_d = POS_CAP;
						sat_d = 1'b1;
					end else begin
						end_d = end_ext[15:0];
					end
				end
			end
		end
	end

	// Report an element end, or the end of the string
	always_comb begin
		has_result         = last || ends;
		result.elem_valid  = have_d;
		result.elem_start  = have_d ? start_d : 16'd0;
		result.elem_end    = have_d ? end_d : 16'd0;
		result.string_done = last;
		result.overflow    = sat_d;
	end

	// Commit state; the last byte returns everything to its start values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			level_q <= 8'd1;
			quote_q <= 1'b0;
			skip_q  <= 1'b0;
			have_q  <= 1'b0;
			start_q <= '0;
			end_q   <= '0;
			sat_q   <= 1'b0;
		end else if (fire) begin
			if (last) begin
				pos_q   <= '0;
				level_q <= 8'd1;
				quote_q <= 1'b0;
				skip_q  <= 1'b0;
				have_q  <= 1'b0;
				start_q <= '0;
				end_q   <= '0;
				sat_q   <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				level_q <= level_d;
				quote_q <= quote_d;
				skip_q  <= skip_d;
				sat_q   <= sat_d;
				have_q  <= ends ? 1'b0 : have_d;
				start_q <= ends ? 16'd0 : start_d;
				end_q   <= ends ? 16'd0 : end_d;
			end
		end
	end

	`NLES_ASSERT_SAME(a_level_range, 1'b1, (level_q != 8'd0) && (level_q <= DEPTH_CAP), "nesting level out of range")
	`NLES_ASSERT_SAME(a_elem_order, have_q, end_q >= start_q, "pending element ends before it starts")
	`NLES_ASSERT_NEXT(a_restart, fire && last, (pos_q == 16'd0) && !have_q && !sat_q && !quote_q, "state not cleared after last byte")
	`NLES_ASSERT_SAME(a_opener_silent, fire && !last && (pos_q == 16'd0), !has_result, "outer opener produced a result")

endmodule

FILE: src/nested_list_element_splitter_top.sv
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------------
// in      | in_valid / in_ready  | ch, last
// out     | out_valid / out_ready| elem_valid, elem_start, elem_end, string_done, overflow
//
// One byte per cycle sustained while the output side does not stall.
// A byte waits in the input register and its result in the result register.
// A byte that ends no element and is not last passes without waiting on the output side.
// A waiting result stalls only a byte that would produce another result.
// Reset (arst_n low) empties both registers and starts a new string.

module nested_list_element_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        elem_valid,
	output logic [15:0] elem_start,
	output logic [15:0] elem_end,
	output logic        string_done,
	output logic        overflow
);
	import nles_pkg::*;

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	logic         has_result;
	logic         advance;
	nles_result_t result;
	nles_result_t res_q;
	logic         out_valid_q;

	// Move the held byte on when its result, if any, has room
	assign advance  = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	nles_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.ch         (ch_s1),
		.last       (last_s1),
		.has_result (has_result),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign elem_valid  = res_q.elem_valid;
	assign elem_start  = res_q.elem_start;
	assign elem_end    = res_q.elem_end;
	assign string_done = res_q.string_done;
	assign overflow    = res_q.overflow;

endmodule
